// ----- src/sgc_pkg.sv -----
// Shared types and constants for the exact-gcd subset counter.
// No dependencies; imported by every module of the block.
`default_nettype none
package sgc_pkg;

  localparam int unsigned MOD_W = 31;
  localparam int unsigned VAL_W = 12;
  localparam int unsigned OP_W = 2;
  localparam int unsigned MUL_CNT_W = $clog2(MOD_W + 1);
  localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_QUERY,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [VAL_W-1:0]  value;
  } item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_WR,
    ST_S_ISSUE,
    ST_S_TAKE,
    ST_P_BIT,
    ST_P_SQ,
    ST_P_DBL,
    ST_P_WR,
    ST_M_RDK,
    ST_M_TAKEK,
    ST_M_ISSUE,
    ST_M_TAKE,
    ST_M_WR,
    ST_Q_RD,
    ST_Q_OUT
  } state_t;

  // (x + y) mod m, both operands below m
  function automatic logic [MOD_W-1:0] modadd(input logic [MOD_W-1:0] x,
                                              input logic [MOD_W-1:0] y,
                                              input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MOD_W-1:0];
  endfunction

  // (x - y) mod m, both operands below m
  function automatic logic [MOD_W-1:0] modsub(input logic [MOD_W-1:0] x,
                                              input logic [MOD_W-1:0] y,
                                              input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] d;
    if (x >= y) d = x - y;
    else d = x + (m - y);
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- src/sgc_front.sv -----
// Front end: takes input transfers, classifies them and drops those with no effect.
// Depends on sgc_pkg.
`default_nettype none
module sgc_front
  import sgc_pkg::*;
#(
  parameter int unsigned MAX_VALUE = 4096
) (
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire logic [OP_W-1:0]  opcode,
  input  wire logic [VAL_W-1:0] value,
  input  wire logic             q_full,
  output logic                  q_push,
  output item_t                 q_item
);

  logic accept;
  logic keep;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;

  always_comb begin
    keep         = 1'b0;
    q_item.kind  = KIND_LOAD;
    q_item.value = value;
    unique case (opcode)
      OP_LOAD: begin
        keep        = 32'(value) < 32'(MAX_VALUE);
        q_item.kind = KIND_LOAD;
      end
      OP_QUERY: begin
        keep        = 1'b1;
        q_item.kind = KIND_QUERY;
      end
      OP_CLEAR: begin
        keep        = 1'b1;
        q_item.kind = KIND_CLEAR;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = accept && keep;

endmodule
`default_nettype wire

// ----- src/sgc_queue.sv -----
// Two-entry queue between front end and back end.
// Depends on sgc_pkg.
`default_nettype none
module sgc_queue
  import sgc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      push_item,
  output logic       full,
  output logic       head_valid,
  output item_t      head_item,
  input  wire logic  pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = fill == 2'd2;
  assign head_valid = fill != 2'd0;
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- src/sgc_back.sv -----
// Back end: histogram, sieve pass, modular power and answer store.
// Depends on sgc_pkg.
`default_nettype none
module sgc_back
  import sgc_pkg::*;
#(
  parameter int unsigned MAX_VALUE = 4096,
  parameter int unsigned MAX_ITEMS = 65535
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  item_t                  q_item,
  output logic                   q_pop,
  input  wire logic [MOD_W-1:0]  modulus,
  input  wire logic              cfg_write,
  output logic                   res_valid,
  input  wire logic              res_take,
  output logic [VAL_W-1:0]       res_value,
  output logic [MOD_W-1:0]       res_count
);

  localparam int unsigned AW  = $clog2(MAX_VALUE);
  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CCW = $clog2(CW + 1);

  state_t state, state_next;

  logic [CW-1:0]  hist [MAX_VALUE];
  logic [MOD_W-1:0] ans [MAX_VALUE];
  logic [CW-1:0]  hist_rd;
  logic [MOD_W-1:0] ans_rd;

  logic [AW-1:0]  hist_raddr, hist_waddr, ans_raddr;
  logic           hist_we, ans_we;
  logic [CW-1:0]  hist_wdata;
  logic [MOD_W-1:0] ans_wdata;

  logic [AW:0]    k, j, clr_addr;
  logic [CW-1:0]  count, cshift, cnt_sum;
  logic [CCW-1:0] ccnt;
  logic [MOD_W-1:0] r, acc, mb, a, m_eff, acc_dbl, acc_step, r_init;
  logic [MUL_CNT_W-1:0] mcnt;
  logic [AW-1:0]  largest;
  logic [CW-1:0]  items;
  logic           ready, hit;
  logic [VAL_W-1:0] cur_value;
  logic [AW:0]    j_step, k2;
  logic           load_ok, q_hit;

  assign m_eff    = (modulus == '0) ? MOD_W'(1) : modulus;
  assign r_init   = (m_eff == MOD_W'(1)) ? '0 : MOD_W'(1);
  assign acc_dbl  = modadd(acc, acc, m_eff);
  assign acc_step = mb[MOD_W-1] ? modadd(acc_dbl, r, m_eff) : acc_dbl;
  assign cnt_sum  = count + hist_rd;
  assign j_step   = j + k;
  assign k2       = {k[AW-1:0], 1'b0};
  assign load_ok  = items < CW'(MAX_ITEMS);
  assign q_hit    = (q_item.value != '0) && (32'(q_item.value) <= 32'(largest));

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (hist_we) hist[hist_waddr] <= hist_wdata;
    hist_rd <= hist[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (ans_we) ans[k[AW-1:0]] <= ans_wdata;
    ans_rd <= ans[ans_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_addr == (AW+1)'(MAX_VALUE - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.kind)
            KIND_LOAD:  if (load_ok) state_next = ST_LOAD_WR;
            KIND_CLEAR: state_next = ST_CLEAR;
            KIND_QUERY: begin
              if (ready || largest == '0) state_next = ST_Q_RD;
              else state_next = ST_S_ISSUE;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_WR: state_next = ST_IDLE;
      ST_S_ISSUE: state_next = ST_S_TAKE;
      ST_S_TAKE:  state_next = (j_step > (AW+1)'(largest)) ? ST_P_BIT : ST_S_ISSUE;
      ST_P_BIT:   state_next = (ccnt == '0) ? ST_P_WR : ST_P_SQ;
      ST_P_SQ: begin
        if (mcnt == MUL_CNT_W'(1)) state_next = cshift[CW-1] ? ST_P_DBL : ST_P_BIT;
      end
      ST_P_DBL:   state_next = ST_P_BIT;
      ST_P_WR: begin
        if (k + 1'b1 > (AW+1)'(largest)) state_next = ST_M_RDK;
        else state_next = ST_S_ISSUE;
      end
      ST_M_RDK:   state_next = ST_M_TAKEK;
      ST_M_TAKEK: state_next = (k2 > (AW+1)'(largest)) ? ST_M_WR : ST_M_ISSUE;
      ST_M_ISSUE: state_next = ST_M_TAKE;
      ST_M_TAKE:  state_next = (j_step > (AW+1)'(largest)) ? ST_M_WR : ST_M_ISSUE;
      ST_M_WR:    state_next = (k == (AW+1)'(1)) ? ST_Q_RD : ST_M_RDK;
      ST_Q_RD:    state_next = ST_Q_OUT;
      ST_Q_OUT:   if (res_take) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    q_pop      = 1'b0;
    hist_we    = 1'b0;
    hist_waddr = clr_addr[AW-1:0];
    hist_wdata = '0;
    hist_raddr = j[AW-1:0];
    ans_we     = 1'b0;
    ans_wdata  = a;
    ans_raddr  = j[AW-1:0];
    res_valid  = 1'b0;
    unique case (state)
      ST_CLEAR: hist_we = 1'b1;
      ST_IDLE: begin
        q_pop      = q_valid;
        hist_raddr = AW'(q_item.value);
      end
      ST_LOAD_WR: begin
        hist_we    = 1'b1;
        hist_waddr = AW'(cur_value);
        hist_wdata = hist_rd + 1'b1;
      end
      ST_P_WR: begin
        ans_we    = 1'b1;
        ans_wdata = (r == '0) ? m_eff - 1'b1 : r - 1'b1;
      end
      ST_M_RDK: ans_raddr = k[AW-1:0];
      ST_M_WR:  ans_we = 1'b1;
      ST_Q_RD:  ans_raddr = AW'(cur_value);
      // keep the answer steady while the result waits
      ST_Q_OUT: begin
        res_valid = 1'b1;
        ans_raddr = AW'(cur_value);
      end
      default: ;
    endcase
  end

  assign res_value = cur_value;
  assign res_count = hit ? ans_rd : '0;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      largest  <= '0;
      items    <= '0;
      ready    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == ST_IDLE && q_valid && q_item.kind == KIND_CLEAR) begin
        clr_addr <= '0;
        largest  <= '0;
        items    <= '0;
        ready    <= 1'b0;
      end
      if (state == ST_LOAD_WR) begin
        items <= items + 1'b1;
        ready <= 1'b0;
        if (AW'(cur_value) > largest) largest <= AW'(cur_value);
      end
      if (state == ST_IDLE && q_valid && q_item.kind == KIND_QUERY && largest == '0)
        ready <= 1'b1;
      if (state == ST_M_WR && k == (AW+1)'(1)) ready <= 1'b1;
      if (cfg_write) ready <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur_value <= q_item.value;
        hit       <= q_hit;
        k         <= (AW+1)'(1);
        j         <= (AW+1)'(1);
        count     <= '0;
      end
      ST_S_TAKE: begin
        count <= cnt_sum;
        j     <= j_step;
        if (j_step > (AW+1)'(largest)) begin
          cshift <= cnt_sum;
          ccnt   <= CCW'(CW);
          r      <= r_init;
        end
      end
      ST_P_BIT: begin
        acc  <= '0;
        mb   <= r;
        mcnt <= MUL_CNT_W'(MOD_W);
      end
      ST_P_SQ: begin
        acc  <= acc_step;
        mb   <= {mb[MOD_W-2:0], 1'b0};
        mcnt <= mcnt - 1'b1;
        if (mcnt == MUL_CNT_W'(1)) begin
          r <= acc_step;
          if (!cshift[CW-1]) begin
            cshift <= {cshift[CW-2:0], 1'b0};
            ccnt   <= ccnt - 1'b1;
          end
        end
      end
      ST_P_DBL: begin
        r      <= modadd(r, r, m_eff);
        cshift <= {cshift[CW-2:0], 1'b0};
        ccnt   <= ccnt - 1'b1;
      end
      ST_P_WR: begin
        if (k + 1'b1 > (AW+1)'(largest)) begin
          k <= (AW+1)'(largest);
        end else begin
          k     <= k + 1'b1;
          j     <= k + 1'b1;
          count <= '0;
        end
      end
      ST_M_TAKEK: begin
        a <= ans_rd;
        j <= k2;
      end
      ST_M_TAKE: begin
        a <= modsub(a, ans_rd, m_eff);
        j <= j_step;
      end
      ST_M_WR: k <= k - 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTH
  a_hist_wr_src: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> (state == ST_CLEAR || state == ST_LOAD_WR))
    else $error("histogram written outside load or clear");

  a_items_cap: assert property (@(posedge clk) disable iff (rst)
    items <= CW'(MAX_ITEMS))
    else $error("item count beyond limit");

  a_load_counts: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD_WR |=> items == $past(items) + 1'b1)
    else $error("load did not bump item count");

  a_sieve_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_S_ISSUE || state == ST_M_ISSUE) |-> j <= (AW+1)'(largest))
    else $error("sieve index past largest value");
`endif

endmodule
`default_nettype wire

// ----- src/subset_gcd_counter_core.sv -----
// A load holds the back end in its idle and load-write states; a query on ready answers
// passes the answer-store read and the output register. The first query after a load or
// modulus write runs the sieve: per k, an issue and a take per multiple read, then a
// modular power over the CW count bits (square; double on a one bit) and an answer
// write, then a downward pass subtracting the answers of each k's multiples.
// Reset (synchronous) and clear opcode sweep all MAX_VALUE histogram entries.
`default_nettype none
module subset_gcd_counter_core
  import sgc_pkg::*;
#(
  parameter int unsigned MAX_VALUE = 4096,
  parameter int unsigned MAX_ITEMS = 65535
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [1:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire logic [OP_W-1:0]  opcode,
  input  wire logic [VAL_W-1:0] value,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output logic [VAL_W-1:0]      queried_value,
  output logic [MOD_W-1:0]      subset_count
);

  logic [MOD_W-1:0] modulus;
  logic             cfg_write;
  logic             q_push, q_full, q_valid, q_pop;
  item_t            push_item, head_item;
  logic             res_valid, res_take;
  logic [VAL_W-1:0] res_value;
  logic [MOD_W-1:0] res_count;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == 2'b00);
  assign prdata    = (paddr == 2'b00) ? {1'b0, modulus} : '0;

  always_ff @(posedge clk) begin
    if (rst) modulus <= MOD_RESET;
    else if (cfg_write) modulus <= pwdata[MOD_W-1:0];
  end

  sgc_front #(.MAX_VALUE(MAX_VALUE)) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .opcode     (opcode),
    .value      (value),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  sgc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (q_valid),
    .head_item  (head_item),
    .pop        (q_pop)
  );

  sgc_back #(.MAX_VALUE(MAX_VALUE), .MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .modulus   (modulus),
    .cfg_write (cfg_write),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_value (res_value),
    .res_count (res_count)
  );

  // output register
  assign res_take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      queried_value <= res_value;
      subset_count  <= res_count;
    end
  end

endmodule
`default_nettype wire
